>>> design/drs_pkg.sv
package drs_pkg;

  localparam int CORE_CLIENTS_DEF = 15;
  localparam int MAX_LEVELS_DEF   = 9;
  localparam int MAX_STEPS_DEF    = 8;

  localparam int NCLIENT    = 16;
  localparam int NCOL       = 16;
  localparam int CPU_VOLTS  = 9;
  localparam int CORE_VOLTS = 8;
  localparam int NVOLT      = CPU_VOLTS + CORE_VOLTS;
  localparam int WR_CAP     = 19;

  localparam logic [21:0] TARGET_MAX = 22'h3FFFFF;

  localparam logic [1:0] RAIL_CPU  = 2'd0;
  localparam logic [1:0] RAIL_CORE = 2'd1;
  localparam logic [1:0] RAIL_RTC  = 2'd2;

  localparam logic [2:0] CFG_MARGIN   = 3'd0;
  localparam logic [2:0] CFG_WINDOW   = 3'd1;
  localparam logic [2:0] CFG_STEP     = 3'd2;
  localparam logic [2:0] CFG_CPU_MAX  = 3'd3;
  localparam logic [2:0] CFG_CORE_MAX = 3'd4;

  localparam logic [18:0] MARGIN_RST   = 19'd100000;
  localparam logic [18:0] WINDOW_RST   = 19'd170000;
  localparam logic [18:0] STEP_RST     = 19'd150000;
  localparam logic [20:0] CPU_MAX_RST  = 21'd1125000;
  localparam logic [20:0] CORE_MAX_RST = 21'd1300000;

  typedef enum logic [2:0] {
    OP_RATE_PRE, OP_RATE_POST, OP_ENABLE_PRE, OP_DISABLE_POST,
    OP_TIMEOUT, OP_SUSPEND, OP_RESUME, OP_INIT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  client;
    logic [31:0] prev_rate;
    logic [31:0] next_rate;
    logic        clock_in_use;
    logic [20:0] cpu_now_uv;
    logic [20:0] core_now_uv;
    logic [20:0] rtc_now_uv;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  rail;
    logic [21:0] target_uv;
    logic        last_write;
  } out_item_t;

  typedef struct packed {
    logic [18:0] margin;
    logic [18:0] window;
    logic [18:0] step;
    logic [20:0] cpu_max;
    logic [20:0] core_max;
  } cfg_t;

  // one voltage update handed from front to back
  typedef struct packed {
    logic        use_max;
    logic [20:0] cpu_t;
    logic [20:0] core_t;
    logic [20:0] cpu_now;
    logic [20:0] core_now;
    logic [20:0] rtc_now;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_EXEC, F_LVL, F_SCAN, F_PUSH
  } front_st_t;

  typedef enum logic [3:0] {
    B_IDLE, B_PREP, B_ORDER, B_CPU1, B_WIN, B_DIV, B_STR, B_STC,
    B_FINAL, B_CPU2, B_FLUSH
  } back_st_t;

  // frequency thresholds in kHz, for the cpu and the core clients alike
  localparam logic [19:0] FREQ_TBL [NCLIENT][NCOL] = '{
    '{0:20'd216, 1:20'd312, 2:20'd456, 3:20'd608, 4:20'd750, 5:20'd760,
      6:20'd816, 7:20'd912, 8:20'd1000, default:20'd0},
    '{3:20'd148500, default:20'd0},
    '{1:20'd150000, 2:20'd300000, 3:20'd600000, default:20'd0},
    '{0:20'd104500, 1:20'd133000, 2:20'd166000, default:20'd0},
    '{0:20'd133000, 1:20'd171000, 2:20'd247000, 3:20'd300000, default:20'd0},
    '{0:20'd133000, 1:20'd171000, 2:20'd247000, 3:20'd300000, default:20'd0},
    '{0:20'd142500, 1:20'd190000, 2:20'd275500, 3:20'd300000, default:20'd0},
    '{0:20'd142500, 1:20'd190000, 2:20'd275500, 3:20'd300000, default:20'd0},
    '{0:20'd85000, 1:20'd100000, 2:20'd150000, default:20'd0},
    '{4:20'd72000, default:20'd0},
    '{0:20'd123500, 1:20'd159500, 2:20'd207000, 3:20'd240000, 4:20'd264000,
      5:20'd277500, default:20'd0},
    '{0:20'd123500, 1:20'd152000, 2:20'd237500, 3:20'd300000, default:20'd0},
    '{0:20'd40000, 1:20'd40000, 2:20'd40000, 3:20'd40000, 4:20'd60000,
      default:20'd0},
    '{0:20'd400000, 1:20'd400000, 2:20'd400000, 3:20'd480000, default:20'd0},
    '{2:20'd480000, default:20'd0},
    '{0:20'd400000, 1:20'd400000, 2:20'd400000, 3:20'd480000, default:20'd0}
  };

  localparam logic [4:0] FREQ_CNT [NCLIENT] = '{
    5'd9, 5'd4, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4, 5'd4,
    5'd3, 5'd5, 5'd6, 5'd4, 5'd5, 5'd4, 5'd3, 5'd4
  };

  // cpu millivolts first, then core millivolts
  localparam logic [10:0] VOLT_MV [NVOLT] = '{
    11'd750, 11'd775, 11'd825, 11'd875, 11'd925, 11'd950, 11'd1000, 11'd1100,
    11'd1125, 11'd1100, 11'd1125, 11'd1150, 11'd1200, 11'd1225, 11'd1250,
    11'd1275, 11'd1300
  };

  function automatic logic [29:0] freq_hz(logic [3:0] c, logic [3:0] i);
    return 30'(FREQ_TBL[c][i]) * 30'd1000;
  endfunction

  function automatic logic [20:0] volt_uv(logic [4:0] idx);
    return 21'(VOLT_MV[idx]) * 21'd1000;
  endfunction

endpackage

>>> design/drs_front.sv
module drs_front #(
  parameter int CORE_CLIENTS = drs_pkg::CORE_CLIENTS_DEF,
  parameter int MAX_LEVELS   = drs_pkg::MAX_LEVELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  drs_pkg::in_item_t in_item,
  output logic             busy,
  input  logic             q_full,
  output logic             q_push,
  output drs_pkg::job_t    q_job
);
  import drs_pkg::*;

  localparam logic [3:0] CC4 = 4'(CORE_CLIENTS);
  localparam logic [4:0] ML5 = 5'(MAX_LEVELS);

  front_st_t  st_r, st_nxt;
  in_item_t   it_r, it_nxt;
  logic [3:0] lvl_r [NCLIENT];
  logic [3:0] lvl_nxt [NCLIENT];
  logic       act_r [NCLIENT];
  logic       act_nxt [NCLIENT];
  logic       pnd_r [NCLIENT];
  logic       pnd_nxt [NCLIENT];
  logic       en_r, en_nxt;
  logic       upd_r, upd_nxt;
  logic       sus_r, sus_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] sc_r, sc_nxt;
  logic [3:0] best_r, best_nxt;

  logic       in_range, is_core;
  logic [4:0] len;
  logic [4:0] cpu_idx, core_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      en_r  <= 1'b0;
      for (int i = 0; i < NCLIENT; i++) begin
        lvl_r[i] <= '0;
        act_r[i] <= 1'b0;
        pnd_r[i] <= 1'b0;
      end
    end else begin
      st_r <= st_nxt;
      en_r <= en_nxt;
      for (int i = 0; i < NCLIENT; i++) begin
        lvl_r[i] <= lvl_nxt[i];
        act_r[i] <= act_nxt[i];
        pnd_r[i] <= pnd_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    it_r   <= it_nxt;
    upd_r  <= upd_nxt;
    sus_r  <= sus_nxt;
    idx_r  <= idx_nxt;
    sc_r   <= sc_nxt;
    best_r <= best_nxt;
  end

  assign in_range = it_r.client <= CC4;
  assign is_core  = in_range && (it_r.client != 4'd0);
  assign len      = (FREQ_CNT[it_r.client] > ML5) ? ML5 : FREQ_CNT[it_r.client];
  assign cpu_idx  = (lvl_r[0] >= 4'(CPU_VOLTS)) ? 5'(CPU_VOLTS - 1) : {1'b0, lvl_r[0]};
  assign core_idx = (best_r >= 4'(CORE_VOLTS)) ? 5'(NVOLT - 1)
                                                : 5'(CPU_VOLTS) + {1'b0, best_r};

  always_comb begin
    st_nxt   = st_r;
    it_nxt   = it_r;
    lvl_nxt  = lvl_r;
    act_nxt  = act_r;
    pnd_nxt  = pnd_r;
    en_nxt   = en_r;
    upd_nxt  = upd_r;
    sus_nxt  = sus_r;
    idx_nxt  = idx_r;
    sc_nxt   = sc_r;
    best_nxt = best_r;
    q_push   = 1'b0;
    busy     = (st_r != F_IDLE);
    unique case (st_r)
      F_IDLE: begin
        if (start) begin
          it_nxt = in_item;
          st_nxt = F_EXEC;
        end
      end
      F_EXEC: begin
        st_nxt   = F_IDLE;
        sus_nxt  = 1'b0;
        idx_nxt  = '0;
        sc_nxt   = 4'd1;
        best_nxt = '0;
        unique case (it_r.op)
          OP_SUSPEND: begin
            for (int i = 1; i < NCLIENT; i++) begin
              if (pnd_r[i]) act_nxt[i] = 1'b0;
              pnd_nxt[i] = 1'b0;
            end
            sus_nxt = 1'b1;
            en_nxt  = 1'b0;
            if (en_r) st_nxt = F_PUSH;
          end
          OP_RESUME: begin
            en_nxt = 1'b1;
            st_nxt = F_SCAN;
          end
          OP_RATE_PRE, OP_RATE_POST: begin
            upd_nxt = 1'b1;
            if (in_range && ((it_r.op == OP_RATE_PRE) ? (it_r.next_rate > it_r.prev_rate)
                                                       : (it_r.next_rate < it_r.prev_rate)))
              st_nxt = F_LVL;
          end
          OP_ENABLE_PRE: begin
            if (is_core && !it_r.clock_in_use) begin
              if (!act_r[it_r.client]) begin
                act_nxt[it_r.client] = 1'b1;
                if (en_r) st_nxt = F_SCAN;
              end else begin
                pnd_nxt[it_r.client] = 1'b0;
              end
            end
          end
          OP_DISABLE_POST: begin
            if (is_core && !it_r.clock_in_use) begin
              if (en_r) pnd_nxt[it_r.client] = 1'b1;
              else act_nxt[it_r.client] = 1'b0;
            end
          end
          OP_TIMEOUT: begin
            if (is_core && pnd_r[it_r.client]) begin
              pnd_nxt[it_r.client] = 1'b0;
              act_nxt[it_r.client] = 1'b0;
              if (en_r) st_nxt = F_SCAN;
            end
          end
          OP_INIT: begin
            if (in_range) begin
              pnd_nxt[it_r.client] = 1'b0;
              act_nxt[it_r.client] = it_r.clock_in_use;
              upd_nxt = 1'b0;
              st_nxt  = F_LVL;
            end
          end
          default: ;
        endcase
      end
      F_LVL: begin
        // one threshold per cycle, lowest level that covers the rate
        if ((5'(idx_r) + 5'd1 < len) && ({2'b0, freq_hz(it_r.client, idx_r)} < it_r.next_rate))
        begin
          idx_nxt = idx_r + 4'd1;
        end else begin
          lvl_nxt[it_r.client] = idx_r;
          st_nxt = (upd_r && en_r) ? F_SCAN : F_IDLE;
        end
      end
      F_SCAN: begin
        if (act_r[sc_r] && (lvl_r[sc_r] > best_r)) best_nxt = lvl_r[sc_r];
        if (sc_r == CC4) st_nxt = F_PUSH;
        else sc_nxt = sc_r + 4'd1;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    q_job.use_max  = sus_r;
    q_job.cpu_t    = volt_uv(cpu_idx);
    q_job.core_t   = volt_uv(core_idx);
    q_job.cpu_now  = it_r.cpu_now_uv;
    q_job.core_now = it_r.core_now_uv;
    q_job.rtc_now  = it_r.rtc_now_uv;
  end

endmodule

>>> design/drs_queue.sv
module drs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  drs_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output drs_pkg::job_t dout,
  output logic          empty
);
  import drs_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt  = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (pop && !empty) begin
      rp_nxt  = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

endmodule

>>> design/drs_back.sv
module drs_back #(
  parameter int MAX_STEPS = drs_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  drs_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  drs_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  output drs_pkg::out_item_t out_item
);
  import drs_pkg::*;

  localparam int CW = $clog2(MAX_STEPS + 1);

  back_st_t           st_r, st_nxt;
  job_t               job_r, job_nxt;
  logic signed [23:0] cpu_t_r, cpu_t_nxt;
  logic signed [23:0] core_t_r, core_t_nxt;
  logic signed [23:0] cur_r, cur_nxt;
  logic [22:0]        rem_r, rem_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               first_r, first_nxt;
  logic               win_r, win_nxt;
  logic               up_r, up_nxt;
  logic [4:0]         wr_r, wr_nxt;
  logic               pend_v_r, pend_v_nxt;
  out_item_t          pend_r, pend_nxt;
  logic               ov_r, ov_nxt;
  out_item_t          out_r, out_nxt;

  logic               gen;
  logic [1:0]         gen_rail;
  logic signed [23:0] gen_val;
  logic signed [23:0] cpu_now, core_now, rtc_now, margin, step_s;
  logic signed [23:0] cpu_sel, core_sel, delta, adelta, gap_abs, stepped, gap_raw;

  assign cpu_now  = 24'(job_r.cpu_now);
  assign core_now = 24'(job_r.core_now);
  assign rtc_now  = 24'(job_r.rtc_now);
  assign margin   = 24'(cfg.margin);
  assign step_s   = 24'(cfg.step);
  assign cpu_sel  = job_r.use_max ? 24'(cfg.cpu_max) : 24'(job_r.cpu_t);
  assign core_sel = job_r.use_max ? 24'(cfg.core_max) : 24'(job_r.core_t);
  assign delta    = core_t_r - rtc_now;
  assign adelta   = delta[23] ? -delta : delta;
  assign gap_raw  = core_t_r - core_now;
  assign gap_abs  = gap_raw[23] ? -gap_raw : gap_raw;

  always_comb begin
    stepped = up_r ? cur_r + step_s : cur_r - step_s;
    if (stepped < 0) stepped = '0;
    else if (stepped > 24'(TARGET_MAX)) stepped = 24'(TARGET_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    cpu_t_r  <= cpu_t_nxt;
    core_t_r <= core_t_nxt;
    cur_r    <= cur_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    first_r  <= first_nxt;
    win_r    <= win_nxt;
    up_r     <= up_nxt;
    wr_r     <= wr_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    job_nxt    = job_r;
    cpu_t_nxt  = cpu_t_r;
    core_t_nxt = core_t_r;
    cur_nxt    = cur_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    win_nxt    = win_r;
    up_nxt     = up_r;
    q_pop      = 1'b0;
    gen        = 1'b0;
    gen_rail   = RAIL_CPU;
    gen_val    = cpu_t_r;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          st_nxt  = B_PREP;
        end
      end
      B_PREP: begin
        cpu_t_nxt  = cpu_sel;
        core_t_nxt = (core_sel < cpu_sel + margin) ? cpu_sel + margin : core_sel;
        st_nxt     = B_ORDER;
      end
      B_ORDER: begin
        first_nxt = core_t_r < cpu_now + margin;
        win_nxt   = adelta > 24'(cfg.window);
        up_nxt    = delta > 0;
        rem_nxt   = gap_abs[22:0];
        cnt_nxt   = '0;
        cur_nxt   = core_now;
        st_nxt    = (core_t_r < cpu_now + margin) ? B_CPU1 : B_WIN;
      end
      B_CPU1: begin
        gen    = (cpu_now != cpu_t_r);
        st_nxt = B_WIN;
      end
      B_WIN: begin
        if (win_r) begin
          gen      = (rtc_now != core_now);
          gen_rail = RAIL_RTC;
          gen_val  = core_now;
          st_nxt   = B_DIV;
        end else begin
          st_nxt = B_FINAL;
        end
      end
      B_DIV: begin
        // repeated subtraction quotient, capped at MAX_STEPS
        if ((cfg.step != '0) && (cnt_r < CW'(MAX_STEPS)) && (rem_r >= 23'(cfg.step))) begin
          rem_nxt = rem_r - 23'(cfg.step);
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          st_nxt = (cnt_r == '0) ? B_FINAL : B_STR;
        end
      end
      B_STR: begin
        gen      = 1'b1;
        gen_rail = RAIL_RTC;
        gen_val  = stepped;
        cur_nxt  = stepped;
        st_nxt   = B_STC;
      end
      B_STC: begin
        gen      = 1'b1;
        gen_rail = RAIL_CORE;
        gen_val  = cur_r;
        cnt_nxt  = cnt_r - CW'(1);
        st_nxt   = (cnt_r == CW'(1)) ? B_FINAL : B_STR;
      end
      B_FINAL: begin
        gen      = (cur_r != core_t_r);
        gen_rail = RAIL_CORE;
        gen_val  = core_t_r;
        st_nxt   = first_r ? B_FLUSH : B_CPU2;
      end
      B_CPU2: begin
        gen    = (cpu_now != cpu_t_r);
        st_nxt = B_FLUSH;
      end
      B_FLUSH: st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // one write is held back so the final one can carry last_write
  always_comb begin
    wr_nxt     = wr_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    ov_nxt     = 1'b0;
    out_nxt    = out_r;
    if (st_r == B_IDLE) wr_nxt = '0;
    if (gen && (wr_r < 5'(WR_CAP))) begin
      wr_nxt = wr_r + 5'd1;
      if (pend_v_r) begin
        ov_nxt             = 1'b1;
        out_nxt            = pend_r;
        out_nxt.last_write = 1'b0;
      end
      pend_v_nxt         = 1'b1;
      pend_nxt.rail      = gen_rail;
      pend_nxt.target_uv = gen_val[21:0];
      pend_nxt.last_write = 1'b0;
    end
    if ((st_r == B_FLUSH) && pend_v_r) begin
      ov_nxt             = 1'b1;
      out_nxt            = pend_r;
      out_nxt.last_write = 1'b1;
      pend_v_nxt         = 1'b0;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = out_r;

endmodule

>>> design/dvfs_rail_sequencer.sv
// Voltage sequencer for one cpu clock and up to CORE_CLIENTS core clocks. An event is taken
// when start is high and busy is low; busy covers the front end only: a decode step, a
// level lookup of one threshold per cycle (up to MAX_LEVELS), the core level scan of one
// core client per cycle, and a push step that hands the update on and waits while the queue
// is full. Updates wait in a two-entry queue and the back end turns each into regulator
// writes: setup states, a state for each possible plain write, a division that counts the
// joint steps by repeated subtraction, an rtc write and then a core write per step, and a
// flush state to finish. Each write appears for exactly one cycle on out_valid/out_item, at
// most nineteen per event, the last marked by last_write; the receiver has to take every
// write when it comes. Writes trail the event because one write is held back to learn
// whether it is the last.
module dvfs_rail_sequencer #(
  parameter int CORE_CLIENTS = drs_pkg::CORE_CLIENTS_DEF,
  parameter int MAX_LEVELS   = drs_pkg::MAX_LEVELS_DEF,
  parameter int MAX_STEPS    = drs_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  drs_pkg::in_item_t  in_item,
  output logic               out_valid,
  output drs_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [20:0]        cfg_wdata
);
  import drs_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_pop, q_empty;
  job_t q_din, q_dout;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MARGIN:   cfg_nxt.margin   = cfg_wdata[18:0];
        CFG_WINDOW:   cfg_nxt.window   = cfg_wdata[18:0];
        CFG_STEP:     cfg_nxt.step     = cfg_wdata[18:0];
        CFG_CPU_MAX:  cfg_nxt.cpu_max  = cfg_wdata;
        CFG_CORE_MAX: cfg_nxt.core_max = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin   <= MARGIN_RST;
      cfg_r.window   <= WINDOW_RST;
      cfg_r.step     <= STEP_RST;
      cfg_r.cpu_max  <= CPU_MAX_RST;
      cfg_r.core_max <= CORE_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  drs_front #(
    .CORE_CLIENTS(CORE_CLIENTS),
    .MAX_LEVELS  (MAX_LEVELS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_item(in_item),
    .busy   (busy),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_din)
  );

  drs_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  drs_back #(
    .MAX_STEPS(MAX_STEPS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_job    (q_dout),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
